/* rtl/nis_pkg.sv */
// Shared types and constants for the Newton integer square root block.
package nis_pkg;

    // Width of the root field on the result channel.
    localparam int unsigned ROOT_BITS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } nis_state_t;

endpackage

/* rtl/nis_radicand_if.sv */
// Input channel interface carrying one radicand per transaction.
interface nis_radicand_if #(
    parameter int unsigned RADICAND_BITS = 32
);
    logic                     valid;
    logic                     ready;
    logic [RADICAND_BITS-1:0] radicand;

    modport source (output valid, output radicand, input ready);
    modport sink (input valid, input radicand, output ready);
endinterface

/* rtl/nis_root_if.sv */
// Output channel interface carrying one root per transaction.
interface nis_root_if
    import nis_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ROOT_BITS-1:0] root;

    modport source (output valid, output root, input ready);
    modport sink (input valid, input root, output ready);
endinterface

/* rtl/nis_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module nis_div #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH:0]   trial;

    // The dividend shifts out of the top of the quotient register while
    // quotient bits shift in at the bottom.
    assign trial = {rem_reg, quo_reg[WIDTH-1]} - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDTH])
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[WIDTH-2:0], quo_reg[WIDTH-1]};
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/newton_integer_sqrt_top.sv */
// Top level: Newton integer square root sequencer around a single divider.
//
//   Channel       Direction  Payload                       Handshake
//   radicand_ch   in         radicand, RADICAND_BITS bits  valid / ready
//   root_ch       out        root, 16 bits                 valid / ready
//
// Each Newton step passes through the load, divide and check states, the
// divide state waiting on the bit-serial divider (one quotient bit per
// cycle). The last step for a radicand only confirms convergence.
// Radicands 0 and 1 finish with no division.
// Reset is asynchronous and active low; it clears the sequencer and the
// output valid flag. The input is not ready while an item is in progress.
// A finished root sits in the output register until taken, so the next
// radicand is accepted while the previous root still waits.
module newton_integer_sqrt_top
    import nis_pkg::*;
#(
    parameter int unsigned RADICAND_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    nis_radicand_if.sink radicand_ch,
    nis_root_if.source   root_ch
);

    localparam int unsigned W = RADICAND_BITS;

    nis_state_t           state_reg, state_next;
    logic [W-1:0]         n_reg, n_next;
    logic [W-1:0]         x_reg, x_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic                 div_start;
    logic                 div_done;
    logic [W-1:0]         quotient;
    logic [W:0]           guess;
    logic                 in_take;

    nis_div #(
        .WIDTH (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (x_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // floor((x + n/x) / 2), formed one bit wider so the sum cannot wrap.
    assign guess = ({1'b0, x_reg} + {1'b0, quotient}) >> 1;

    assign radicand_ch.ready = (state_reg == ST_IDLE);
    assign in_take           = radicand_ch.valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg;
        root_next      = root_reg;
        div_start      = 1'b0;

        if (out_valid_reg && root_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    n_next = radicand_ch.radicand;
                    if (radicand_ch.radicand[W-1:1] == '0)
                    begin
                        // Zero and one are their own roots.
                        x_next     = radicand_ch.radicand;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        x_next = {1'b0, radicand_ch.radicand[W-1:1]}
                               + W'(radicand_ch.radicand[0]);
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (guess >= {1'b0, x_reg})
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    x_next     = guess[W-1:0];
                    state_next = ST_LOAD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || root_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    root_next      = ROOT_BITS'(x_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        x_reg    <= x_next;
        root_reg <= root_next;
    end

    assign root_ch.valid = out_valid_reg;
    assign root_ch.root  = root_reg;

endmodule
